FILE: design/apple2_soft_switch_block_core_macros.svh
// Assertion macros shared by the checker files.
`ifndef APPLE2_SOFT_SWITCH_BLOCK_CORE_MACROS_SVH
`define APPLE2_SOFT_SWITCH_BLOCK_CORE_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold in that cycle.
`define A2SSW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define A2SSW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/a2ssw_pkg.sv
`timescale 1ns / 1ps

package a2ssw_pkg;

   // Transaction kinds on the request channel
   typedef enum logic [1:0] {
      KIND_BUS  = 2'd0,
      KIND_KEY  = 2'd1,
      KIND_POLL = 2'd2
   } kind_type;

   // Channel widths
   localparam int REQ_TDATA_W = 40;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_W       = 28;
   localparam int RSP_TDATA_W = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   // Register index of the mode register (taken from paddr[2])
   localparam logic CSR_IDX_IIE_MODE = 1'b0;

   // Default type-ahead depth
   localparam int TYPE_AHEAD_DEPTH = 16;

   // Video timing
   localparam logic [14:0] FRAME_CYCLES   = 15'd17030;
   localparam logic [14:0] VISIBLE_CYCLES = 15'd12480;

   // Key folding
   localparam logic [6:0] KEY_LOWER_A  = 7'h61;
   localparam logic [6:0] KEY_LOWER_Z  = 7'h7A;
   localparam logic [6:0] KEY_CASE_OFS = 7'h20;

   // Video flag bit positions
   localparam int V_TEXT   = 0;
   localparam int V_DHIRES = 4;
   localparam int V_COL80  = 5;
   localparam int V_ALTCHR = 6;

   // Language card bit positions
   localparam int L_BANK2 = 0;
   localparam int L_READ  = 1;
   localparam int L_WRITE = 2;
   localparam int L_PRE   = 3;

   // MMU bit positions
   localparam int M_STORE80 = 0;
   localparam int M_RAMRD   = 1;
   localparam int M_RAMWRT  = 2;
   localparam int M_INTCX   = 3;
   localparam int M_ALTZP   = 4;
   localparam int M_SLOTC3  = 5;

   // IIe write switch selects in C000-C00F (address bits 3:1)
   localparam logic [2:0] IIE_SW_COL80  = 3'd6;
   localparam logic [2:0] IIE_SW_ALTCHR = 3'd7;

   // Soft-switch addresses within the C0xx page
   localparam logic [7:0] ADDR_KBD      = 8'h00;
   localparam logic [7:0] ADDR_KBDSTRB  = 8'h10;
   localparam logic [7:0] ADDR_RDLCBNK2 = 8'h11;
   localparam logic [7:0] ADDR_RDLCRAM  = 8'h12;
   localparam logic [7:0] ADDR_RDRAMRD  = 8'h13;
   localparam logic [7:0] ADDR_RDRAMWRT = 8'h14;
   localparam logic [7:0] ADDR_RDCXROM  = 8'h15;
   localparam logic [7:0] ADDR_RDALTZP  = 8'h16;
   localparam logic [7:0] ADDR_RDC3ROM  = 8'h17;
   localparam logic [7:0] ADDR_RD80STOR = 8'h18;
   localparam logic [7:0] ADDR_RDVBLBAR = 8'h19;
   localparam logic [7:0] ADDR_RDTEXT   = 8'h1A;
   localparam logic [7:0] ADDR_RDMIXED  = 8'h1B;
   localparam logic [7:0] ADDR_RDPAGE2  = 8'h1C;
   localparam logic [7:0] ADDR_RDHIRES  = 8'h1D;
   localparam logic [7:0] ADDR_RDALTCHR = 8'h1E;
   localparam logic [7:0] ADDR_IIE_END  = 8'h20;
   localparam logic [7:0] ADDR_SPKR     = 8'h30;
   localparam logic [7:0] ADDR_TXTCLR   = 8'h50;
   localparam logic [7:0] ADDR_PAGE2OFF = 8'h54;
   localparam logic [7:0] ADDR_DHIRESON = 8'h5E;
   localparam logic [7:0] ADDR_DHIRESOF = 8'h5F;
   localparam logic [7:0] ADDR_PB0      = 8'h61;
   localparam logic [7:0] ADDR_PB1      = 8'h62;
   localparam logic [7:0] ADDR_LC_BASE  = 8'h80;
   localparam logic [7:0] ADDR_SLOT_IO  = 8'h90;

endpackage

FILE: design/a2ssw_ram.sv
`timescale 1ns / 1ps

module a2ssw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port, registered read port (old data on a same-address write)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

FILE: design/apple2_soft_switch_block_core.sv
// An accepted request's result is registered in the result register or in the skid stage.
// Throughput: one transaction per cycle while rsp takes results. The result register plus a
// skid stage keep req_tready high while one result waits; it drops once both are full.
// Reset: synchronous, active high; clears all switch, latch and queue pointer state.
// The type-ahead storage is not cleared; only entries written since reset are ever read.
`timescale 1ns / 1ps

module apple2_soft_switch_block_core #(
   parameter int TYPE_AHEAD_DEPTH = a2ssw_pkg::TYPE_AHEAD_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata: address_low[7:0], is_write[8], key_code[15:9], key_held[16],
   //        buttons[18:17], frame_cycle[33:19], zero fill[39:34]
   input  logic [a2ssw_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [a2ssw_pkg::REQ_TUSER_W-1:0] req_tuser,
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata: read_data[7:0], speaker_level[8], video_flags[15:9], memory_flags[24:16],
   //        remap_needed[25], lc_remap_needed[26], key_dropped[27], zero fill[31:28]
   output logic [a2ssw_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [a2ssw_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [a2ssw_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [a2ssw_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                              csr_pready
);

   localparam int PTR_W = (TYPE_AHEAD_DEPTH > 1) ? $clog2(TYPE_AHEAD_DEPTH) : 1;
   localparam int CNT_W = $clog2(TYPE_AHEAD_DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(TYPE_AHEAD_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(TYPE_AHEAD_DEPTH);
   localparam logic [SUM_W-1:0] SUM_DEPTH = SUM_W'(TYPE_AHEAD_DEPTH);

   // Request fields
   a2ssw_pkg::kind_type kind;
   logic [7:0]  addr;
   logic        wr;
   logic [6:0]  code;
   logic        held;
   logic [1:0]  btn;
   logic [14:0] fc;

   assign kind = a2ssw_pkg::kind_type'(req_tuser);
   assign addr = req_tdata[7:0];
   assign wr   = req_tdata[8];
   assign code = req_tdata[15:9];
   assign held = req_tdata[16];
   assign btn  = req_tdata[18:17];
   assign fc   = req_tdata[33:19];

   // State registers
   logic              iie_ff;
   logic [6:0]        video_ff, video_in;
   logic [3:0]        lc_ff, lc_in, lc_next;
   logic [5:0]        mmu_ff, mmu_in;
   logic [7:0]        latch_ff, latch_in;
   logic              spk_ff, spk_in;
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              fwd_vld_ff, fwd_vld_in;
   logic [6:0]        fwd_code_ff;

   // Output stage registers
   logic              out_vld_ff;
   logic [a2ssw_pkg::RSP_W-1:0] out_data_ff;
   logic              skid_vld_ff;
   logic [a2ssw_pkg::RSP_W-1:0] skid_data_ff;

   logic              accept;
   logic              push;
   logic              pop;
   logic [7:0]        data;
   logic              remap;
   logic              lcremap;
   logic              dropped;
   logic              flag;
   logic [6:0]        key_fold;
   logic [14:0]       fc_mod;
   logic              vbl_flag;
   logic [SUM_W-1:0]  tail_sum;
   logic [PTR_W-1:0]  tail;
   logic [6:0]        ram_rd_data;
   logic [6:0]        head_code;
   logic [a2ssw_pkg::RSP_W-1:0] result;
   logic              csr_wr;

   assign req_tready = !skid_vld_ff;
   assign accept     = req_tvalid && req_tready;

   // Configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == a2ssw_pkg::CSR_IDX_IIE_MODE) ?
                       {{(a2ssw_pkg::CSR_DATA_W-1){1'b0}}, iie_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         iie_ff <= 1'b0;
      end else if (csr_wr && csr_paddr[2] == a2ssw_pkg::CSR_IDX_IIE_MODE) begin
         iie_ff <= csr_pwdata[0];
      end
   end

   // Vertical-blank status: frame_cycle stays below twice the frame length
   assign fc_mod   = (fc >= a2ssw_pkg::FRAME_CYCLES) ? (fc - a2ssw_pkg::FRAME_CYCLES) : fc;
   assign vbl_flag = fc_mod < a2ssw_pkg::VISIBLE_CYCLES;

   // Language card bank, read enable and double-read write enable
   always_comb begin
      lc_next = 4'd0;
      lc_next[a2ssw_pkg::L_WRITE] = lc_ff[a2ssw_pkg::L_WRITE];
      lc_next[a2ssw_pkg::L_BANK2] = !addr[3];
      lc_next[a2ssw_pkg::L_READ]  = (addr[1:0] == 2'b00) || (addr[1:0] == 2'b11);
      if (addr[0]) begin
         if (!wr) begin
            if (lc_ff[a2ssw_pkg::L_PRE]) begin
               lc_next[a2ssw_pkg::L_WRITE] = 1'b1;
            end
            lc_next[a2ssw_pkg::L_PRE] = 1'b1;
         end
      end else begin
         lc_next[a2ssw_pkg::L_WRITE] = 1'b0;
      end
   end

   // Type-ahead queue pointers and head entry
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_DEPTH) ? PTR_W'(tail_sum - SUM_DEPTH) : PTR_W'(tail_sum);
   assign head_code = fwd_vld_ff ? fwd_code_ff : ram_rd_data;
   assign key_fold  = (!iie_ff && code >= a2ssw_pkg::KEY_LOWER_A && code <= a2ssw_pkg::KEY_LOWER_Z) ?
                      (code - a2ssw_pkg::KEY_CASE_OFS) : code;

   // Decode one transaction into next state and result
   always_comb begin
      video_in = video_ff;
      mmu_in   = mmu_ff;
      lc_in    = lc_ff;
      latch_in = latch_ff;
      spk_in   = spk_ff;
      data     = 8'd0;
      remap    = 1'b0;
      lcremap  = 1'b0;
      dropped  = 1'b0;
      push     = 1'b0;
      pop      = 1'b0;
      flag     = 1'b0;
      case (kind)
         a2ssw_pkg::KIND_BUS: begin
            if (addr < a2ssw_pkg::ADDR_SLOT_IO) begin
               if (iie_ff && addr < a2ssw_pkg::ADDR_IIE_END) begin
                  if (!addr[4]) begin
                     if (!wr) begin
                        data = latch_ff;
                     end else begin
                        case (addr[3:1])
                           a2ssw_pkg::IIE_SW_COL80: begin
                              video_in[a2ssw_pkg::V_COL80] = addr[0];
                           end
                           a2ssw_pkg::IIE_SW_ALTCHR: begin
                              video_in[a2ssw_pkg::V_ALTCHR] = addr[0];
                           end
                           default: begin
                              mmu_in[addr[3:1]] = addr[0];
                              remap = 1'b1;
                           end
                        endcase
                     end
                  end else if (wr || addr == a2ssw_pkg::ADDR_KBDSTRB) begin
                     // Clear the strobe; a read also shows the key-held status
                     latch_in[7] = 1'b0;
                     data = wr ? 8'd0 : {held, latch_ff[6:0]};
                  end else begin
                     case (addr)
                        a2ssw_pkg::ADDR_RDLCBNK2: flag = lc_ff[a2ssw_pkg::L_BANK2];
                        a2ssw_pkg::ADDR_RDLCRAM:  flag = lc_ff[a2ssw_pkg::L_READ];
                        a2ssw_pkg::ADDR_RDRAMRD:  flag = mmu_ff[a2ssw_pkg::M_RAMRD];
                        a2ssw_pkg::ADDR_RDRAMWRT: flag = mmu_ff[a2ssw_pkg::M_RAMWRT];
                        a2ssw_pkg::ADDR_RDCXROM:  flag = mmu_ff[a2ssw_pkg::M_INTCX];
                        a2ssw_pkg::ADDR_RDALTZP:  flag = mmu_ff[a2ssw_pkg::M_ALTZP];
                        a2ssw_pkg::ADDR_RDC3ROM:  flag = mmu_ff[a2ssw_pkg::M_SLOTC3];
                        a2ssw_pkg::ADDR_RD80STOR: flag = mmu_ff[a2ssw_pkg::M_STORE80];
                        a2ssw_pkg::ADDR_RDVBLBAR: flag = vbl_flag;
                        a2ssw_pkg::ADDR_RDTEXT:   flag = video_ff[0];
                        a2ssw_pkg::ADDR_RDMIXED:  flag = video_ff[1];
                        a2ssw_pkg::ADDR_RDPAGE2:  flag = video_ff[2];
                        a2ssw_pkg::ADDR_RDHIRES:  flag = video_ff[3];
                        a2ssw_pkg::ADDR_RDALTCHR: flag = video_ff[a2ssw_pkg::V_ALTCHR];
                        default:                  flag = video_ff[a2ssw_pkg::V_COL80];
                     endcase
                     data = {flag, latch_ff[6:0]};
                  end
               end else begin
                  case (addr)
                     a2ssw_pkg::ADDR_KBD: begin
                        data = latch_ff;
                     end
                     a2ssw_pkg::ADDR_KBDSTRB: begin
                        latch_in[7] = 1'b0;
                        data = {1'b0, latch_ff[6:0]};
                     end
                     a2ssw_pkg::ADDR_SPKR: begin
                        spk_in = !spk_ff;
                     end
                     a2ssw_pkg::ADDR_DHIRESON: begin
                        video_in[a2ssw_pkg::V_DHIRES] = 1'b1;
                     end
                     a2ssw_pkg::ADDR_DHIRESOF: begin
                        video_in[a2ssw_pkg::V_DHIRES] = 1'b0;
                     end
                     a2ssw_pkg::ADDR_PB0: begin
                        data = {btn[0], 7'd0};
                     end
                     a2ssw_pkg::ADDR_PB1: begin
                        data = {btn[1], 7'd0};
                     end
                     default: begin
                     end
                  endcase
                  // Text, mixed, page2 and hires: even address clears, odd sets
                  if (addr[7:3] == a2ssw_pkg::ADDR_TXTCLR[7:3]) begin
                     video_in[addr[2:1]] = addr[0];
                  end
                  if (iie_ff && addr[7:2] == a2ssw_pkg::ADDR_PAGE2OFF[7:2] &&
                      mmu_ff[a2ssw_pkg::M_STORE80]) begin
                     remap = 1'b1;
                  end
                  if (addr[7:4] == a2ssw_pkg::ADDR_LC_BASE[7:4]) begin
                     lc_in   = lc_next;
                     lcremap = 1'b1;
                  end
               end
            end
         end
         a2ssw_pkg::KIND_KEY: begin
            if (key_fold != 7'd0) begin
               if (count_ff == CNT_FULL) begin
                  dropped = 1'b1;
               end else begin
                  push = 1'b1;
               end
            end
         end
         a2ssw_pkg::KIND_POLL: begin
            if (count_ff != '0 && !latch_ff[7]) begin
               pop      = 1'b1;
               latch_in = {1'b1, head_code};
            end
         end
         default: begin
         end
      endcase
   end

   // Queue pointer updates
   always_comb begin
      head_in    = head_ff;
      count_in   = count_ff;
      fwd_vld_in = 1'b0;
      if (accept && push) begin
         count_in   = count_ff + CNT_W'(1);
         fwd_vld_in = (count_ff == '0);
      end else if (accept && pop) begin
         head_in  = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign result = {dropped, lcremap, remap, mmu_in, lc_in[2:0], video_in, spk_in, data};

   // Advance switch and queue state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         video_ff   <= 7'd1 << a2ssw_pkg::V_TEXT;
         lc_ff      <= 4'd0;
         mmu_ff     <= 6'd0;
         latch_ff   <= 8'd0;
         spk_ff     <= 1'b0;
         head_ff    <= '0;
         count_ff   <= '0;
         fwd_vld_ff <= 1'b0;
      end else begin
         fwd_vld_ff <= fwd_vld_in;
         head_ff    <= head_in;
         count_ff   <= count_in;
         if (accept) begin
            video_ff <= video_in;
            lc_ff    <= lc_in;
            mmu_ff   <= mmu_in;
            latch_ff <= latch_in;
            spk_ff   <= spk_in;
         end
      end
   end

   // Hold the code just written to an empty queue until the memory read catches up
   always_ff @(posedge clock) begin
      if (accept && push) begin
         fwd_code_ff <= key_fold;
      end
   end

   a2ssw_ram #(
      .WIDTH (7),
      .DEPTH (TYPE_AHEAD_DEPTH)
   ) u_fifo_ram (
      .clock   (clock),
      .wr_en   (accept && push),
      .wr_addr (tail),
      .wr_data (key_fold),
      .rd_addr (head_in),
      .rd_data (ram_rd_data)
   );

   // Result register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= accept;
         end
      end else if (accept) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            out_data_ff <= skid_data_ff;
         end else if (accept) begin
            out_data_ff <= result;
         end
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {{(a2ssw_pkg::RSP_TDATA_W - a2ssw_pkg::RSP_W){1'b0}}, out_data_ff};

endmodule

FILE: design/a2ssw_checker.sv
`timescale 1ns / 1ps
`include "apple2_soft_switch_block_core_macros.svh"

module a2ssw_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [a2ssw_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A stalled response keeps its payload
   `A2SSW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp payload changed while stalled")

   // Every new response follows an accepted request
   `A2SSW_ASSERT_IMPL(a_rsp_cause, clock, reset, $rose(rsp_tvalid), $past(req_tvalid && req_tready), "rsp appeared without an accepted request")

   // Fill bits above the result fields stay zero
   `A2SSW_ASSERT_IMPL(a_rsp_fill, clock, reset, rsp_tvalid, rsp_tdata[31:28] == 4'd0, "rsp fill bits not zero")

   // A dropped key comes from a key press, never from a bus access
   `A2SSW_ASSERT_IMPL(a_drop_kind, clock, reset, rsp_tvalid && rsp_tdata[27], rsp_tdata[7:0] == 8'd0 && !rsp_tdata[26] && !rsp_tdata[25], "key drop mixed with bus results")

endmodule

bind apple2_soft_switch_block_core a2ssw_checker u_a2ssw_checker (.*);

FILE: tb/apple2_soft_switch_block_core_tb.sv
`timescale 1ns / 1ps

module apple2_soft_switch_block_core_tb;

   // Kind code outside the defined set; the block must ignore it
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // Extra soft-switch addresses used by the directed transactions
   localparam logic [7:0] ADDR_SETSTORE80 = 8'h01;
   localparam logic [7:0] ADDR_PLUS_UNUSED = 8'h05;
   localparam logic [7:0] ADDR_SETALTCHR = 8'h0F;
   localparam logic [7:0] ADDR_RD80COL = 8'h1F;
   localparam logic [7:0] ADDR_PAGE2ON = 8'h55;
   localparam logic [7:0] ADDR_LC_ROM_WE = 8'h81;
   localparam logic [7:0] ADDR_LC_BANK1_RD = 8'h88;
   localparam logic [7:0] ADDR_PAGE_TOP = 8'hFF;

   // Video flag positions not named by the package
   localparam int V_MIXED = 1;
   localparam int V_PAGE2 = 2;
   localparam int V_HIRES = 3;

   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int REPORT_LIMIT = 10;
   localparam int QIDX_W = $clog2(a2ssw_pkg::TYPE_AHEAD_DEPTH);

   typedef enum int {
      TAKE_ALWAYS,
      TAKE_HALF,
      TAKE_SLOW
   } take_mode_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  addr;
      logic        wr;
      logic [6:0]  code;
      logic        held;
      logic [1:0]  btn;
      logic [14:0] fc;
   } switch_request_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       speaker;
      logic [6:0] video;
      logic [8:0] memory;
      logic       remap;
      logic       lc_remap;
      logic       dropped;
   } switch_result_type;

   // Soft-switch state tracker with the queue of results still owed by the block
   class soft_switch_scoreboard;
      logic               iie;
      logic [6:0]         video;
      logic [3:0]         lc;
      logic [5:0]         mmu;
      logic [7:0]         latch;
      logic [6:0]         type_ahead [a2ssw_pkg::TYPE_AHEAD_DEPTH];
      int                 head;
      int                 count;
      logic               spk;
      switch_result_type  pending_results[$];
      int                 errors;

      function new();
         iie = 1'b0;
         video = '0;
         video[a2ssw_pkg::V_TEXT] = 1'b1;
         lc = '0;
         mmu = '0;
         latch = '0;
         head = 0;
         count = 0;
         spk = 1'b0;
         errors = 0;
      endfunction

      function void set_mode(logic mode);
         iie = mode;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Advance the switch state by one request and queue the result it owes
      function void note_request(switch_request_type r);
         switch_result_type e;
         logic [6:0]        code;
         logic              flag;
         logic [3:0]        lc_next;
         e = '0;
         case (r.kind)
            a2ssw_pkg::KIND_BUS: begin
               if (r.addr >= a2ssw_pkg::ADDR_SLOT_IO) begin
                  // slot I/O reads zero with no effect
               end else if (iie && r.addr < a2ssw_pkg::ADDR_IIE_END) begin
                  if (r.addr < a2ssw_pkg::ADDR_KBDSTRB) begin
                     if (!r.wr) begin
                        e.read_data = latch;
                     end else begin
                        // address bits 3:1 pick the switch, bit 0 is on/off
                        case (r.addr[3:1])
                           a2ssw_pkg::IIE_SW_COL80: video[a2ssw_pkg::V_COL80] = r.addr[0];
                           a2ssw_pkg::IIE_SW_ALTCHR: video[a2ssw_pkg::V_ALTCHR] = r.addr[0];
                           default: begin
                              mmu[r.addr[3:1]] = r.addr[0];
                              e.remap = 1'b1;
                           end
                        endcase
                     end
                  end else if (r.wr || r.addr == a2ssw_pkg::ADDR_KBDSTRB) begin
                     latch[7] = 1'b0;
                     if (!r.wr) e.read_data = {r.held, latch[6:0]};
                  end else begin
                     case (r.addr)
                        a2ssw_pkg::ADDR_RDLCBNK2: flag = lc[a2ssw_pkg::L_BANK2];
                        a2ssw_pkg::ADDR_RDLCRAM: flag = lc[a2ssw_pkg::L_READ];
                        a2ssw_pkg::ADDR_RDRAMRD: flag = mmu[a2ssw_pkg::M_RAMRD];
                        a2ssw_pkg::ADDR_RDRAMWRT: flag = mmu[a2ssw_pkg::M_RAMWRT];
                        a2ssw_pkg::ADDR_RDCXROM: flag = mmu[a2ssw_pkg::M_INTCX];
                        a2ssw_pkg::ADDR_RDALTZP: flag = mmu[a2ssw_pkg::M_ALTZP];
                        a2ssw_pkg::ADDR_RDC3ROM: flag = mmu[a2ssw_pkg::M_SLOTC3];
                        a2ssw_pkg::ADDR_RD80STOR: flag = mmu[a2ssw_pkg::M_STORE80];
                        a2ssw_pkg::ADDR_RDVBLBAR:
                           flag = (r.fc % a2ssw_pkg::FRAME_CYCLES) < a2ssw_pkg::VISIBLE_CYCLES;
                        a2ssw_pkg::ADDR_RDTEXT: flag = video[a2ssw_pkg::V_TEXT];
                        a2ssw_pkg::ADDR_RDMIXED: flag = video[V_MIXED];
                        a2ssw_pkg::ADDR_RDPAGE2: flag = video[V_PAGE2];
                        a2ssw_pkg::ADDR_RDHIRES: flag = video[V_HIRES];
                        a2ssw_pkg::ADDR_RDALTCHR: flag = video[a2ssw_pkg::V_ALTCHR];
                        default: flag = video[a2ssw_pkg::V_COL80];
                     endcase
                     e.read_data = {flag, latch[6:0]};
                  end
               end else if (r.addr == a2ssw_pkg::ADDR_KBD) begin
                  e.read_data = latch;
               end else if (r.addr == a2ssw_pkg::ADDR_KBDSTRB) begin
                  latch[7] = 1'b0;
                  e.read_data = latch;
               end else if (r.addr == a2ssw_pkg::ADDR_PB0) begin
                  e.read_data = {r.btn[0], 7'd0};
               end else if (r.addr == a2ssw_pkg::ADDR_PB1) begin
                  e.read_data = {r.btn[1], 7'd0};
               end else begin
                  if (r.addr == a2ssw_pkg::ADDR_SPKR) spk = ~spk;
                  // C050-C057: bits 2:1 pick text/mixed/page2/hires, bit 0 sets
                  if (r.addr[7:3] == a2ssw_pkg::ADDR_TXTCLR[7:3]) video[r.addr[2:1]] = r.addr[0];
                  if (r.addr == a2ssw_pkg::ADDR_DHIRESON) video[a2ssw_pkg::V_DHIRES] = 1'b1;
                  if (r.addr == a2ssw_pkg::ADDR_DHIRESOF) video[a2ssw_pkg::V_DHIRES] = 1'b0;
                  if (iie && r.addr[7:2] == a2ssw_pkg::ADDR_PAGE2OFF[7:2]
                      && mmu[a2ssw_pkg::M_STORE80])
                     e.remap = 1'b1;
                  // language card: odd read twice in a row enables writes
                  if (r.addr[7:4] == a2ssw_pkg::ADDR_LC_BASE[7:4]) begin
                     lc_next = '0;
                     lc_next[a2ssw_pkg::L_WRITE] = lc[a2ssw_pkg::L_WRITE];
                     lc_next[a2ssw_pkg::L_BANK2] = ~r.addr[3];
                     lc_next[a2ssw_pkg::L_READ] = (r.addr[1] == r.addr[0]);
                     if (r.addr[0]) begin
                        if (!r.wr) begin
                           lc_next[a2ssw_pkg::L_WRITE] = lc_next[a2ssw_pkg::L_WRITE]
                                                         | lc[a2ssw_pkg::L_PRE];
                           lc_next[a2ssw_pkg::L_PRE] = 1'b1;
                        end
                     end else begin
                        lc_next[a2ssw_pkg::L_WRITE] = 1'b0;
                     end
                     lc = lc_next;
                     e.lc_remap = 1'b1;
                  end
               end
            end
            a2ssw_pkg::KIND_KEY: begin
               code = r.code;
               if (!iie && code >= a2ssw_pkg::KEY_LOWER_A && code <= a2ssw_pkg::KEY_LOWER_Z)
                  code = code - a2ssw_pkg::KEY_CASE_OFS;
               if (code != 7'd0) begin
                  if (count < a2ssw_pkg::TYPE_AHEAD_DEPTH) begin
                     type_ahead[QIDX_W'((head + count) % a2ssw_pkg::TYPE_AHEAD_DEPTH)] = code;
                     count++;
                  end else begin
                     e.dropped = 1'b1;
                  end
               end
            end
            a2ssw_pkg::KIND_POLL: begin
               if (count != 0 && !latch[7]) begin
                  latch = {1'b1, type_ahead[QIDX_W'(head)]};
                  head = (head + 1) % a2ssw_pkg::TYPE_AHEAD_DEPTH;
                  count--;
               end
            end
            default: ;
         endcase
         e.speaker = spk;
         e.video = video;
         e.memory = {mmu, lc[2:0]};
         pending_results.push_back(e);
      endfunction

      function void flag_mismatch(string field, logic [8:0] want, logic [8:0] got);
         errors++;
         if (errors <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
      endfunction

      // Compare one accepted result with the oldest owed one
      function void check_result(logic [a2ssw_pkg::RSP_TDATA_W-1:0] td);
         switch_result_type want;
         if (pending_results.size() == 0) begin
            errors++;
            if (errors <= REPORT_LIMIT)
               $display("%0t: result %h arrived with none owed", $time, td);
            return;
         end
         want = pending_results.pop_front();
         if (td[7:0] !== want.read_data)
            flag_mismatch("read_data", 9'(want.read_data), 9'(td[7:0]));
         if (td[8] !== want.speaker)
            flag_mismatch("speaker_level", 9'(want.speaker), 9'(td[8]));
         if (td[15:9] !== want.video)
            flag_mismatch("video_flags", 9'(want.video), 9'(td[15:9]));
         if (td[24:16] !== want.memory)
            flag_mismatch("memory_flags", want.memory, td[24:16]);
         if (td[25] !== want.remap)
            flag_mismatch("remap_needed", 9'(want.remap), 9'(td[25]));
         if (td[26] !== want.lc_remap)
            flag_mismatch("lc_remap_needed", 9'(want.lc_remap), 9'(td[26]));
         if (td[27] !== want.dropped)
            flag_mismatch("key_dropped", 9'(want.dropped), 9'(td[27]));
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [a2ssw_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic [a2ssw_pkg::REQ_TUSER_W-1:0] req_tuser;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [a2ssw_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [a2ssw_pkg::CSR_ADDR_W-1:0]  csr_paddr;
   logic [a2ssw_pkg::CSR_DATA_W-1:0]  csr_pwdata;
   logic [a2ssw_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                              csr_pready;

   soft_switch_scoreboard sb = new();
   int                    burst_left = 0;
   int                    hold_requests = 0;
   int                    stall_cycles = 0;

   apple2_soft_switch_block_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   // Check every result transaction against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("apple2_soft_switch_block_core_tb: errors");
            $finish;
         end
      end
   end

   // Result side: switch between take patterns, hold off hard on request
   initial begin
      take_mode_type mode;
      int            pattern_left;
      int            holds_done;
      mode = TAKE_ALWAYS;
      pattern_left = 0;
      holds_done = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            holds_done++;
         end else begin
            if (pattern_left == 0) begin
               mode = take_mode_type'($urandom_range(0, 2));
               pattern_left = $urandom_range(20, 200);
            end
            pattern_left--;
            case (mode)
               TAKE_ALWAYS: rsp_tready = 1'b1;
               TAKE_HALF: rsp_tready = 1'($urandom_range(0, 1));
               default: rsp_tready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic switch_request_type make_item(logic [1:0] kind, logic [7:0] addr,
                                                    logic wr = 1'b0, logic [6:0] code = 7'd0,
                                                    logic held = 1'b0, logic [1:0] btn = 2'd0,
                                                    logic [14:0] fc = 15'd0);
      switch_request_type r;
      r.kind = kind;
      r.addr = addr;
      r.wr = wr;
      r.code = code;
      r.held = held;
      r.btn = btn;
      r.fc = fc;
      return r;
   endfunction

   // Offer one request in bursts separated by random gaps; note it when taken
   task automatic send_req(input switch_request_type r);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      req_tuser = r.kind;
      req_tdata = {6'd0, r.fc, r.btn, r.held, r.code, r.wr, r.addr};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(r);
      burst_left--;
   endtask

   task automatic end_burst();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
   endtask

   // Write the mode register once the block has drained
   task automatic write_mode(input logic mode);
      while (sb.pending() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {a2ssw_pkg::CSR_IDX_IIE_MODE, 2'b00};
      csr_pwdata = $urandom();
      csr_pwdata[0] = mode;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.set_mode(mode);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   // Random traffic biased toward switch pages, key entry and latch draining
   task automatic run_phase(input int n_items, input int key_pct, input int poll_pct);
      switch_request_type r;
      int                 pick;
      int                 sent;
      sent = 0;
      while (sent < n_items) begin
         r.addr = 8'($urandom());
         r.wr = ($urandom_range(0, 3) == 0);
         r.code = 7'($urandom());
         r.held = 1'($urandom_range(0, 1));
         r.btn = 2'($urandom_range(0, 3));
         pick = $urandom_range(0, 99);
         if (pick < 20) r.fc = 15'($urandom_range(12470, 12490));
         else r.fc = 15'($urandom_range(0, 17029));
         pick = $urandom_range(0, 99);
         if (pick < 25)
            r.code = 7'($urandom_range(a2ssw_pkg::KEY_LOWER_A, a2ssw_pkg::KEY_LOWER_Z));
         else if (pick < 30) r.code = 7'd0;
         pick = $urandom_range(0, 99);
         if (pick < key_pct) r.kind = a2ssw_pkg::KIND_KEY;
         else if (pick < key_pct + poll_pct) r.kind = a2ssw_pkg::KIND_POLL;
         else if (pick < key_pct + poll_pct + 3) r.kind = KIND_UNUSED;
         else r.kind = a2ssw_pkg::KIND_BUS;
         if (r.kind == a2ssw_pkg::KIND_BUS) begin
            pick = $urandom_range(0, 99);
            if (pick < 15) r.addr = a2ssw_pkg::ADDR_KBDSTRB;
            else if (pick < 35) r.addr = 8'($urandom_range(0, 31));
            else if (pick < 50) r.addr = {a2ssw_pkg::ADDR_TXTCLR[7:4], 4'($urandom())};
            else if (pick < 72) r.addr = {a2ssw_pkg::ADDR_LC_BASE[7:4], 4'($urandom())};
            else if (pick < 80) begin
               case ($urandom_range(0, 2))
                  0: r.addr = a2ssw_pkg::ADDR_SPKR;
                  1: r.addr = a2ssw_pkg::ADDR_PB0;
                  default: r.addr = a2ssw_pkg::ADDR_PB1;
               endcase
            end
         end
         send_req(r);
         if (r.kind != KIND_UNUSED) sent++;
         // repeat language-card accesses often so the double-read path is reached
         if (r.kind == a2ssw_pkg::KIND_BUS && r.addr[7:4] == a2ssw_pkg::ADDR_LC_BASE[7:4]
             && $urandom_range(0, 1) == 1) begin
            send_req(r);
            sent++;
         end
      end
      end_burst();
   endtask

   initial begin
      int phase;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      @(negedge reset);
      @(negedge clock);

      // II plus set: case folding, empty key, ignored kind, latch and strobe, speaker and buttons
      write_mode(1'b0);
      send_req(make_item(a2ssw_pkg::KIND_KEY, 8'h00, 1'b0, a2ssw_pkg::KEY_LOWER_A));
      send_req(make_item(a2ssw_pkg::KIND_KEY, 8'h00, 1'b0, 7'd0));
      send_req(make_item(KIND_UNUSED, ADDR_PAGE_TOP, 1'b1, 7'h7F, 1'b1, 2'd3, 15'd17029));
      send_req(make_item(a2ssw_pkg::KIND_POLL, 8'h00));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_KBD));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_KBDSTRB));
      send_req(make_item(a2ssw_pkg::KIND_POLL, 8'h00));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_PLUS_UNUSED));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_SPKR));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_PB0, 1'b0, 7'd0, 1'b0, 2'd3));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_PB1, 1'b0, 7'd0, 1'b0, 2'd2));
      // language card: two odd reads enable writes, odd write keeps it and even access drops it
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_LC_ROM_WE));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_LC_ROM_WE));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_LC_ROM_WE, 1'b1));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_LC_BANK1_RD));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_PAGE_TOP, 1'b1));
      end_burst();

      // IIe set: MMU writes, page2 remap, vertical blank edges, status reads, keys
      write_mode(1'b1);
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_SETSTORE80, 1'b1));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_PAGE2ON));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_RDVBLBAR, 1'b0, 7'd0, 1'b0,
                         2'd0, 15'd12479));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_RDVBLBAR, 1'b0, 7'd0, 1'b0,
                         2'd0, a2ssw_pkg::VISIBLE_CYCLES));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_SETALTCHR, 1'b1));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_KBDSTRB, 1'b0, 7'd0, 1'b1));
      send_req(make_item(a2ssw_pkg::KIND_BUS, a2ssw_pkg::ADDR_RDCXROM, 1'b1));
      send_req(make_item(a2ssw_pkg::KIND_KEY, 8'h00, 1'b0, 7'h7F));
      send_req(make_item(a2ssw_pkg::KIND_KEY, 8'h00, 1'b0, a2ssw_pkg::KEY_LOWER_A));
      send_req(make_item(a2ssw_pkg::KIND_BUS, ADDR_RD80COL));
      end_burst();

      // random phases, alternating switch sets; two of them stall the result side
      for (phase = 0; phase < 6; phase++) begin
         write_mode(phase[0]);
         if (phase == 1 || phase == 4) hold_requests++;
         run_phase(305, $urandom_range(10, 40), $urandom_range(10, 35));
      end

      // drain, then let the pipeline settle
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("apple2_soft_switch_block_core_tb: clean");
      end else begin
         $display("apple2_soft_switch_block_core_tb: errors");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+design
design/a2ssw_pkg.sv
design/a2ssw_ram.sv
design/apple2_soft_switch_block_core.sv
design/a2ssw_checker.sv
tb/apple2_soft_switch_block_core_tb.sv
